// File: src/bgr_pkg.sv
// Shared types and constants for the glyph row generator.
`default_nettype none

package bgr_pkg;

  localparam int XW        = 13;
  localparam int YW        = 12;
  localparam int ROW_YW    = 13;
  localparam int ADDR_W    = 32;
  localparam int COLOR_W   = 24;
  localparam int CODE_W    = 8;
  localparam int LIMIT_W   = 8;
  localparam int LINE_W    = 13;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 16;

  localparam logic [CODE_W-1:0] WIDE_FIRST    = 8'hA1;
  localparam logic [CODE_W-1:0] CODE_DROP     = 8'hFF;
  localparam logic [7:0]        CODES_PER_ROW = 8'd94;

  localparam logic [XW-1:0] HALF_STEP = 13'd8;
  localparam logic [XW-1:0] FULL_STEP = 13'd16;

  localparam logic [ADDR_W-1:0] ASCII_BASE_RESET = 32'd0;
  localparam logic [ADDR_W-1:0] HANZI_BASE_RESET = 32'd4096;
  localparam logic [LINE_W-1:0] LINE_WIDTH_RESET = 13'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_ASCII_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HANZI_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  typedef struct packed {
    logic              wide;
    logic [CODE_W-1:0] lead;
    logic [CODE_W-1:0] code;
  } glyph_op_t;

  typedef struct packed {
    logic               wide;
    logic [ADDR_W-1:0]  base;
    logic [XW-1:0]      x;
    logic [YW-1:0]      y;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } row_job_t;

endpackage

`default_nettype wire

// File: src/bgr_base_unit.sv
// Two-stage glyph base address unit: code index, then scale and table offset.
`default_nettype none

module bgr_base_unit
  import bgr_pkg::*;
#(
  parameter int GLYPH_ROWS = 16
) (
  input  wire logic              clk,
  input  wire glyph_op_t         op,
  input  wire logic [ADDR_W-1:0] ascii_base,
  input  wire logic [ADDR_W-1:0] hanzi_base,
  output logic      [ADDR_W-1:0] base
);

  localparam int SCALE_W = $clog2(2 * GLYPH_ROWS) + 1;
  localparam logic [SCALE_W-1:0] NARROW_SCALE = SCALE_W'(GLYPH_ROWS);
  localparam logic [SCALE_W-1:0] WIDE_SCALE   = SCALE_W'(2 * GLYPH_ROWS);
  localparam int PROD_W = IDX_W + SCALE_W + 1;

  logic signed [CODE_W:0]   lead_off;
  logic signed [CODE_W:0]   code_off;
  logic signed [17:0]       lead_prod;
  logic signed [IDX_W-1:0]  idx_next;
  logic signed [IDX_W-1:0]  idx;
  logic                     wide_q;
  logic        [SCALE_W-1:0] scale;
  logic signed [PROD_W-1:0] offset;
  logic        [ADDR_W-1:0] base_next;

  // stage 1: row-major index into the double-byte table, or the plain code
  assign lead_off  = $signed({1'b0, op.lead}) - $signed({1'b0, WIDE_FIRST});
  assign code_off  = $signed({1'b0, op.code}) - $signed({1'b0, WIDE_FIRST});
  assign lead_prod = lead_off * $signed({1'b0, CODES_PER_ROW});

  always_comb begin
    if (op.wide) begin
      idx_next = IDX_W'(lead_prod) + IDX_W'(code_off);
    end else begin
      idx_next = $signed(IDX_W'({1'b0, op.code}));
    end
  end

  // stage 2: bytes per glyph times index, plus table start (mod 2^32)
  assign scale     = wide_q ? WIDE_SCALE : NARROW_SCALE;
  assign offset    = idx * $signed({1'b0, scale});
  assign base_next = (wide_q ? hanzi_base : ascii_base) + ADDR_W'(offset);

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    wide_q <= op.wide;
    base   <= base_next;
  end

endmodule

`default_nettype wire

// File: src/bgr_row_seq.sv
// Row sequencer: steps one address incrementer over the rows of a glyph.
`default_nettype none

module bgr_row_seq
  import bgr_pkg::*;
#(
  parameter int GLYPH_ROWS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire row_job_t           job,
  output logic                    busy,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [XW-1:0]           row_x,
  output logic [ROW_YW-1:0]       row_y,
  output logic [ADDR_W-1:0]       mask_address,
  output logic                    is_wide_font,
  output logic [COLOR_W-1:0]      out_fg,
  output logic [COLOR_W-1:0]      out_bg,
  output logic                    run_end
);

  localparam int K_W = $clog2(2 * GLYPH_ROWS);
  localparam int R_W = $clog2(GLYPH_ROWS);
  localparam logic [K_W-1:0] NARROW_LAST = K_W'(GLYPH_ROWS - 1);
  localparam logic [K_W-1:0] WIDE_LAST   = K_W'(2 * GLYPH_ROWS - 1);

  row_job_t          cur;
  logic [ADDR_W-1:0] addr;
  logic [K_W-1:0]    k;
  logic [K_W-1:0]    k_last;
  logic [R_W-1:0]    r;
  logic              emitting;
  logic              advance;

  // wide glyphs alternate left and right halves, so addresses stay consecutive
  assign advance = emitting && (!out_valid || out_ready);
  assign k_last  = cur.wide ? WIDE_LAST : NARROW_LAST;
  assign r       = cur.wide ? R_W'(k >> 1) : R_W'(k);
  assign busy    = emitting;

  always_ff @(posedge clk) begin
    if (rst) begin
      emitting  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        emitting <= 1'b1;
      end else if (advance && k == k_last) begin
        emitting <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur  <= job;
      addr <= job.base;
      k    <= '0;
    end else if (advance) begin
      addr <= addr + 32'd1;
      k    <= k + K_W'(1);
    end
    if (advance) begin
      row_x        <= (cur.wide && k[0]) ? cur.x + HALF_STEP : cur.x;
      row_y        <= ROW_YW'(cur.y) + ROW_YW'(r);
      mask_address <= addr;
      is_wide_font <= cur.wide;
      out_fg       <= cur.fg;
      out_bg       <= cur.bg;
      run_end      <= (k == k_last);
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst) load |-> !emitting)
    else $error("row job loaded while a glyph is still emitting");
  a_k_range: assert property (@(posedge clk) disable iff (rst) emitting |-> (k <= k_last))
    else $error("row counter ran past the glyph");
  a_start_row: assert property (@(posedge clk) disable iff (rst) $rose(emitting) |-> k == '0)
    else $error("glyph emission did not start at row zero");

endmodule

`default_nettype wire

// File: src/bitmap_text_glyph_row_generator.sv
// Top level of the bitmap text glyph row generator.
//
// Usage: an input transaction with cmd = start latches cursor, colors and a
// byte budget (min of byte_limit and the free line width / 8). Each later
// transaction with cmd = byte carries one string byte. An ASCII byte gives
// GLYPH_ROWS output transactions of 8-pixel mask rows; a double-byte code
// (lead then trail byte) gives 2*GLYPH_ROWS, left and right halves
// interleaved. run_end marks the last row of a byte. Config registers
// (0 ascii_base, 1 hanzi_base, 2 line_width) are written through cfg_write.
// A taken byte passes the index, scale and load states before its first row
// is valid; one that draws a glyph holds in_ready low until its last row (N
// rows, 16 or 32 at the default size) is registered, others leave it high.
// One row leaves per cycle while the receiver is ready, paced by the single
// address incrementer in the row sequencer. When the receiver stalls, the
// output register holds and the sequencer waits; the next input can be taken
// while the last row still waits. Reset (rst, synchronous) restores the
// register defaults, ends any string and drops everything in flight.
`default_nettype none

module bitmap_text_glyph_row_generator
  import bgr_pkg::*;
#(
  parameter int GLYPH_ROWS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // config write port
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 cmd,
  input  wire logic [YW-1:0]        start_x,
  input  wire logic [YW-1:0]        start_y,
  input  wire logic [COLOR_W-1:0]   fg_color,
  input  wire logic [COLOR_W-1:0]   bg_color,
  input  wire logic [LIMIT_W-1:0]   byte_limit,
  input  wire logic [CODE_W-1:0]    char_byte,
  input  wire logic                 end_of_string,
  // output channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [XW-1:0]             row_x,
  output logic [ROW_YW-1:0]         row_y,
  output logic [ADDR_W-1:0]         mask_address,
  output logic                      is_wide_font,
  output logic [COLOR_W-1:0]        out_fg,
  output logic [COLOR_W-1:0]        out_bg,
  output logic                      run_end
);

  // one-hot sequencer: index, scale, hand job to row sequencer, wait for it
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INDEX = 5'b00010,
    S_SCALE = 5'b00100,
    S_LOAD  = 5'b01000,
    S_RUN   = 5'b10000
  } seq_state_t;

  seq_state_t state, state_next;

  // config registers
  logic [ADDR_W-1:0] ascii_base;
  logic [ADDR_W-1:0] hanzi_base;
  logic [LINE_W-1:0] line_width;

  // string state
  logic [XW-1:0]      cursor_x, cursor_x_next;
  logic [YW-1:0]      cursor_y, cursor_y_next;
  logic [COLOR_W-1:0] saved_fg, saved_fg_next;
  logic [COLOR_W-1:0] saved_bg, saved_bg_next;
  logic [LIMIT_W-1:0] bytes_left, bytes_left_next;
  logic [CODE_W-1:0]  lead_code, lead_code_next;
  logic               lead_pending, lead_pending_next;
  logic               string_active, string_active_next;

  // glyph job captured at acceptance
  glyph_op_t          op, op_next;
  logic [XW-1:0]      job_x;
  logic [YW-1:0]      job_y;
  logic [COLOR_W-1:0] job_fg;
  logic [COLOR_W-1:0] job_bg;

  logic               in_accept;
  logic               emit_now;
  logic               wide_now;
  logic [LINE_W-1:0]  line_gap;
  logic [9:0]         room;
  logic [LIMIT_W-1:0] budget;
  logic [ADDR_W-1:0]  glyph_base;
  row_job_t           job;
  logic               busy;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // budget on start: free width in 8-pixel cells, clipped by byte_limit
  assign line_gap = line_width - {1'b0, start_x};
  assign room     = line_gap[LINE_W-1:3];
  always_comb begin
    if ({1'b0, start_x} >= line_width) begin
      budget = '0;
    end else if (room < {2'b00, byte_limit}) begin
      budget = room[LIMIT_W-1:0];
    end else begin
      budget = byte_limit;
    end
  end

  // byte decode and string state update
  always_comb begin
    cursor_x_next      = cursor_x;
    cursor_y_next      = cursor_y;
    saved_fg_next      = saved_fg;
    saved_bg_next      = saved_bg;
    bytes_left_next    = bytes_left;
    lead_code_next     = lead_code;
    lead_pending_next  = lead_pending;
    string_active_next = string_active;
    emit_now           = 1'b0;
    wide_now           = 1'b0;
    if (in_accept) begin
      if (cmd == CMD_START) begin
        cursor_x_next      = {1'b0, start_x};
        cursor_y_next      = start_y;
        saved_fg_next      = fg_color;
        saved_bg_next      = bg_color;
        bytes_left_next    = budget;
        lead_code_next     = '0;
        lead_pending_next  = 1'b0;
        string_active_next = 1'b1;
      end else begin
        if (string_active && bytes_left != '0) begin
          if (lead_pending) begin
            // trail byte; either code byte at 0xFF drops the character
            bytes_left_next   = bytes_left - 8'd1;
            lead_pending_next = 1'b0;
            if (lead_code != CODE_DROP && char_byte != CODE_DROP) begin
              emit_now      = 1'b1;
              wide_now      = 1'b1;
              cursor_x_next = cursor_x + FULL_STEP;
            end
          end else if (char_byte >= WIDE_FIRST) begin
            // lead byte with no room for its trail ends the string
            if (bytes_left == 8'd1) begin
              bytes_left_next = '0;
            end else begin
              bytes_left_next   = bytes_left - 8'd1;
              lead_code_next    = char_byte;
              lead_pending_next = 1'b1;
            end
          end else begin
            bytes_left_next = bytes_left - 8'd1;
            emit_now        = 1'b1;
            cursor_x_next   = cursor_x + HALF_STEP;
          end
        end
        if (end_of_string) begin
          string_active_next = 1'b0;
          bytes_left_next    = '0;
          lead_pending_next  = 1'b0;
          lead_code_next     = '0;
        end
      end
    end
  end

  assign op_next = '{wide: wide_now, lead: lead_code, code: char_byte};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_accept && emit_now) state_next = S_INDEX;
      S_INDEX: state_next = S_SCALE;
      S_SCALE: state_next = S_LOAD;
      S_LOAD:  state_next = S_RUN;
      S_RUN:   if (!busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ascii_base    <= ASCII_BASE_RESET;
      hanzi_base    <= HANZI_BASE_RESET;
      line_width    <= LINE_WIDTH_RESET;
      cursor_x      <= '0;
      cursor_y      <= '0;
      saved_fg      <= '0;
      saved_bg      <= '0;
      bytes_left    <= '0;
      lead_code     <= '0;
      lead_pending  <= 1'b0;
      string_active <= 1'b0;
    end else begin
      state         <= state_next;
      cursor_x      <= cursor_x_next;
      cursor_y      <= cursor_y_next;
      saved_fg      <= saved_fg_next;
      saved_bg      <= saved_bg_next;
      bytes_left    <= bytes_left_next;
      lead_code     <= lead_code_next;
      lead_pending  <= lead_pending_next;
      string_active <= string_active_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_ASCII_BASE: ascii_base <= cfg_data;
          REG_HANZI_BASE: hanzi_base <= cfg_data;
          REG_LINE_WIDTH: line_width <= cfg_data[LINE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // job payload: pre-advance cursor and current colors
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op     <= op_next;
      job_x  <= cursor_x;
      job_y  <= cursor_y;
      job_fg <= saved_fg;
      job_bg <= saved_bg;
    end
  end

  bgr_base_unit #(
    .GLYPH_ROWS(GLYPH_ROWS)
  ) u_base (
    .clk       (clk),
    .op        (op),
    .ascii_base(ascii_base),
    .hanzi_base(hanzi_base),
    .base      (glyph_base)
  );

  assign job = '{wide: op.wide, base: glyph_base, x: job_x, y: job_y,
                 fg: job_fg, bg: job_bg};

  bgr_row_seq #(
    .GLYPH_ROWS(GLYPH_ROWS)
  ) u_rows (
    .clk         (clk),
    .rst         (rst),
    .load        (state == S_LOAD),
    .job         (job),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_x       (row_x),
    .row_y       (row_y),
    .mask_address(mask_address),
    .is_wide_font(is_wide_font),
    .out_fg      (out_fg),
    .out_bg      (out_bg),
    .run_end     (run_end)
  );

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst) busy |-> !in_ready)
    else $error("input taken while rows are still being emitted");
  a_lead_in_string: assert property (@(posedge clk) disable iff (rst)
    lead_pending |-> string_active)
    else $error("lead byte held outside a string");
  a_emit_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_accept && emit_now) |=> !in_ready)
    else $error("drawing byte did not start the sequencer");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> !busy)
    else $error("job handed over while the row sequencer is busy");

endmodule

`default_nettype wire
